// ===== src/mst_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mst_pkg: shared types and constants of the multitouch slot tracker
// Event codes, field widths and the slot record types that pass between the
// slot store, the activity check and the top level.
// ----------------------------------------------------------------------------
package mst_pkg;

    // Slot count and index width
    localparam int SLOTS  = 4;
    localparam int SLOT_W = 2;

    // Field widths
    localparam int OP_W    = 5;
    localparam int CODE_W  = 10;
    localparam int VALUE_W = 32;
    localparam int POS_W   = 16;
    localparam int DIM_W   = 16;

    // Event types
    localparam logic [OP_W-1:0] OP_SYNC = 5'd0;
    localparam logic [OP_W-1:0] OP_KEY  = 5'd1;
    localparam logic [OP_W-1:0] OP_ABS  = 5'd3;

    // Event codes
    localparam logic [CODE_W-1:0] CODE_SLOT  = 10'd47;
    localparam logic [CODE_W-1:0] CODE_POS_X = 10'd53;
    localparam logic [CODE_W-1:0] CODE_POS_Y = 10'd54;
    localparam logic [CODE_W-1:0] CODE_TRACK = 10'd57;
    localparam logic [CODE_W-1:0] CODE_TOUCH = 10'd330;

    // Register indexes
    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    localparam logic [VALUE_W-1:0] NO_VALUE = '1;

    // One incoming event
    typedef struct packed {
        logic               valid;
        logic [OP_W-1:0]    op;
        logic [CODE_W-1:0]  code;
        logic [VALUE_W-1:0] value;
    } event_t;

    // Stored state of one slot; a position keeps only a flag for
    // "fits in 0..65535" plus its low bits
    typedef struct packed {
        logic [VALUE_W-1:0] track_id;
        logic               pressed;
        logic               x_ok;
        logic [POS_W-1:0]   x;
        logic               y_ok;
        logic [POS_W-1:0]   y;
    } slot_rec_t;

    // Result of the activity check
    typedef struct packed {
        logic             active;
        logic [POS_W-1:0] pos_x;
        logic [POS_W-1:0] pos_y;
    } chk_res_t;

endpackage

// ===== src/multitouch_slot_tracker_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multitouch_slot_tracker_unit: protocol B multitouch slot tracker
// Tracks up to four touch contacts from evdev-style events and emits a
// per-slot snapshot on sync and on contact release.
// ----------------------------------------------------------------------------
// An event is taken when s_tvalid and s_tready are both high and updates the
// slot state at once. Events that cause no record leave the block ready on
// the next cycle. A sync event, or a tracking id of -1, starts a snapshot: a
// small sequencer walks the four slots through one shared bounds compare
// unit, one slot per cycle while the output side accepts, and writes each
// record into the output register. Such an event keeps s_tready low until
// the final slot's record is loaded, so output stalls lengthen it; tlast
// marks that record. No new request is taken during a snapshot. The user
// must write display width and height through the register port only while
// the block is idle (the block does not enforce this); they reset to 1920 and 1080.
module multitouch_slot_tracker_unit
    import mst_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    // Register write port
    input  logic             cfg_wr_en,
    input  logic             cfg_addr,
    input  logic [DIM_W-1:0] cfg_wdata,
    // Event requests
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [47:0]      s_tdata,   // op[4:0], code[14:5], value[46:15], zero pad
    // Slot records
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [71:0]      m_tdata,   // slot_index[1:0], active[2], track_id[34:3],
                                        // pressed[35], pos_x[51:36], pos_y[67:52], pad
    output logic             m_tlast
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EMIT = 1'b1;

    logic              state_reg, state_next;
    logic [SLOT_W-1:0] cnt_reg, cnt_next;
    logic [DIM_W-1:0]  width_reg, height_reg;

    logic              out_valid_reg, out_valid_next;
    logic [71:0]       out_data_reg;
    logic              out_last_reg;

    event_t            evt;
    logic              snap_req;
    slot_rec_t         rd_rec;
    chk_res_t          chk;
    logic              out_load;
    logic              cnt_last;

    // Request decode
    assign s_tready  = (state_reg == ST_IDLE);
    assign evt.valid = s_tvalid && s_tready;
    assign evt.op    = s_tdata[4:0];
    assign evt.code  = s_tdata[14:5];
    assign evt.value = s_tdata[46:15];

    mst_slot_store u_store (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .evt      (evt),
        .snap_req (snap_req),
        .rd_slot  (cnt_reg),
        .rd_rec   (rd_rec)
    );

    mst_active_check u_check (
        .rec    (rd_rec),
        .disp_w (width_reg),
        .disp_h (height_reg),
        .res    (chk)
    );

    // Display registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= DIM_W'(1920);
            height_reg <= DIM_W'(1080);
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_WIDTH:  width_reg  <= cfg_wdata;
                CFG_HEIGHT: height_reg <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Snapshot sequencer
    assign out_load = (state_reg == ST_EMIT) && (!out_valid_reg || m_tready);
    assign cnt_last = (cnt_reg == SLOT_W'(SLOTS - 1));

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE: begin
                cnt_next = '0;
                if (snap_req) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_load) begin
                    cnt_next = cnt_reg + SLOT_W'(1);
                    if (cnt_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Output register
    always_comb begin
        out_valid_next = out_valid_reg;
        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_data_reg <= {4'b0, chk.pos_y, chk.pos_x, rd_rec.pressed,
                             rd_rec.track_id, chk.active, cnt_reg};
            out_last_reg <= cnt_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ===== src/mst_slot_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mst_slot_store: selected slot and per-slot contact state
// Applies one event to the state and flags the events that trigger a
// snapshot; serves one slot at a time to the activity check.
// ----------------------------------------------------------------------------
module mst_slot_store
    import mst_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  event_t            evt,
    output logic              snap_req,
    input  logic [SLOT_W-1:0] rd_slot,
    output slot_rec_t         rd_rec
);

    logic [SLOT_W-1:0] sel_reg, sel_next;
    slot_rec_t         slot_reg  [SLOTS];
    slot_rec_t         slot_next [SLOTS];
    slot_rec_t         cur;
    logic              fits16;

    // value is a non-negative 16-bit position
    assign fits16 = (evt.value[VALUE_W-1:POS_W] == '0);

    // Event decode and update of the selected slot
    always_comb begin
        sel_next = sel_reg;
        snap_req = 1'b0;
        for (int k = 0; k < SLOTS; k++) begin
            slot_next[k] = slot_reg[k];
        end
        cur = slot_reg[sel_reg];
        if (evt.valid) begin
            unique case (evt.op)
                OP_SYNC: begin
                    snap_req = 1'b1;
                end
                OP_ABS: begin
                    if (evt.code == CODE_SLOT) begin
                        if (evt.value < VALUE_W'(SLOTS)) begin
                            sel_next = evt.value[SLOT_W-1:0];
                        end
                    end else if (evt.code == CODE_TRACK) begin
                        cur.track_id = evt.value;
                        if (evt.value == NO_VALUE) begin
                            cur.x_ok    = 1'b0;
                            cur.x       = '1;
                            cur.y_ok    = 1'b0;
                            cur.y       = '1;
                            cur.pressed = 1'b0;
                            snap_req    = 1'b1;
                        end
                    end else if (evt.code == CODE_POS_X) begin
                        cur.x_ok = fits16;
                        cur.x    = evt.value[POS_W-1:0];
                    end else if (evt.code == CODE_POS_Y) begin
                        cur.y_ok = fits16;
                        cur.y    = evt.value[POS_W-1:0];
                    end
                end
                OP_KEY: begin
                    if (evt.code == CODE_TOUCH) begin
                        cur.pressed = (evt.value != '0);
                        if (evt.value == '0) begin
                            cur.x_ok     = 1'b0;
                            cur.x        = '1;
                            cur.y_ok     = 1'b0;
                            cur.y        = '1;
                            cur.track_id = NO_VALUE;
                        end
                    end
                end
                default: begin
                end
            endcase
            slot_next[sel_reg] = cur;
        end
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sel_reg <= '0;
            for (int k = 0; k < SLOTS; k++) begin
                slot_reg[k] <= '{track_id: NO_VALUE, pressed: 1'b0, x_ok: 1'b0,
                                 x: '1, y_ok: 1'b0, y: '1};
            end
        end else begin
            sel_reg <= sel_next;
            for (int k = 0; k < SLOTS; k++) begin
                slot_reg[k] <= slot_next[k];
            end
        end
    end

    assign rd_rec = slot_reg[rd_slot];

endmodule

// ===== src/mst_active_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mst_active_check: shared bounds compare unit
// Decides for one slot whether its contact is tracked and on screen, and
// masks the position when it is not.
// ----------------------------------------------------------------------------
module mst_active_check
    import mst_pkg::*;
(
    input  slot_rec_t        rec,
    input  logic [DIM_W-1:0] disp_w,
    input  logic [DIM_W-1:0] disp_h,
    output chk_res_t         res
);

    logic in_x, in_y;

    assign in_x = rec.x_ok && (rec.x < disp_w);
    assign in_y = rec.y_ok && (rec.y < disp_h);

    // Tracked and inside both dimensions
    assign res.active = (rec.track_id != NO_VALUE) && in_x && in_y;
    assign res.pos_x  = res.active ? rec.x : '0;
    assign res.pos_y  = res.active ? rec.y : '0;

endmodule
